>>> hw/rtl/olws_pkg.sv
// Shared types and constants for the ordered list with statistics block.
`timescale 1ns / 1ps
`default_nettype none
package olws_pkg;

    localparam int DEPTH     = 64;
    localparam int ADDR_W    = 6;
    localparam int CNT_W     = 7;
    localparam int KEY_W     = 8;
    localparam int MARK_W    = 16;
    localparam int SUM_W     = 23;
    localparam int DIVD_W    = 30;
    localparam int AVG_W     = 24;
    localparam int STATUS_W  = 3;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_STATS  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    // what the datapath does with the word returned by the store
    localparam logic [2:0] MODE_NONE     = 3'd0;
    localparam logic [2:0] MODE_SHIFT_UP = 3'd1;
    localparam logic [2:0] MODE_SHIFT_DN = 3'd2;
    localparam logic [2:0] MODE_MATCH    = 3'd3;
    localparam logic [2:0] MODE_STATS    = 3'd4;

    localparam logic [1:0] IDX_ZERO   = 2'd0;
    localparam logic [1:0] IDX_CNT_M1 = 2'd1;
    localparam logic [1:0] IDX_HIT_P1 = 2'd2;

    typedef struct packed {
        logic                load;
        logic                rd;
        logic                dir_dn;
        logic [2:0]          mode;
        logic                idx_load;
        logic [1:0]          idx_sel;
        logic                hit_clr;
        logic                wr_new;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                div_start;
        logic                res_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       badpos;
        logic       pos_eq_cnt;
        logic       empty;
        logic       idx_at_pos;
        logic       idx_at_last;
        logic       hit;
        logic       hit_last;
        logic       div_done;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

>>> hw/rtl/olws_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module olws_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [olws_pkg::DIVD_W-1:0]   i_dividend,
    input  wire [olws_pkg::CNT_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [olws_pkg::DIVD_W-1:0]  o_quotient
);
    import olws_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIVD_W-1:0] r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dsr;
    logic [CNT_W:0]    w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_q[DIVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= STEP_W'(DIVD_W - 1);
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? CNT_W'(w_trial - {1'b0, r_dsr}) : w_trial[CNT_W-1:0];
            r_q   <= {r_q[DIVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
`default_nettype wire

>>> hw/rtl/olws_dp.sv
// Datapath: entry store, count, scan index, statistics, divider and result register.
`timescale 1ns / 1ps
`default_nettype none
module olws_dp (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  olws_pkg::t_cmd                i_cmd,
    output olws_pkg::t_sts                o_sts,
    input  wire                           i_cfg_valid,
    input  wire [olws_pkg::CNT_W-1:0]     i_cfg_capacity,
    input  wire [1:0]                     i_operation,
    input  wire [olws_pkg::CNT_W-1:0]     i_position,
    input  wire [olws_pkg::KEY_W-1:0]     i_student_key,
    input  wire signed [olws_pkg::MARK_W-1:0] i_mark,
    input  wire                           i_out_ready,
    output logic                          o_out_valid,
    output logic [olws_pkg::STATUS_W-1:0] o_status,
    output logic [olws_pkg::ADDR_W-1:0]   o_found_index,
    output logic [olws_pkg::CNT_W-1:0]    o_entry_total,
    output logic [olws_pkg::ADDR_W-1:0]   o_max_index,
    output logic [olws_pkg::KEY_W-1:0]    o_max_key,
    output logic signed [olws_pkg::MARK_W-1:0] o_max_mark,
    output logic [olws_pkg::ADDR_W-1:0]   o_min_index,
    output logic [olws_pkg::KEY_W-1:0]    o_min_key,
    output logic signed [olws_pkg::MARK_W-1:0] o_min_mark,
    output logic signed [olws_pkg::AVG_W-1:0]  o_average_mark
);
    import olws_pkg::*;

    localparam int WORD_W = KEY_W + MARK_W;

    logic [WORD_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0]    r_capacity;
    logic [CNT_W-1:0]    r_count;
    logic [1:0]          r_op;
    logic [CNT_W-1:0]    r_pos;
    logic [KEY_W-1:0]    r_key;
    logic [MARK_W-1:0]   r_mark;
    logic [CNT_W-1:0]    r_idx;
    logic                r_rd_vld;
    logic [ADDR_W-1:0]   r_rd_idx;
    logic [WORD_W-1:0]   r_rdata;
    logic                r_hit;
    logic [ADDR_W-1:0]   r_hit_idx;
    logic [STATUS_W-1:0] r_status;
    logic [ADDR_W-1:0]   r_hi_idx, r_lo_idx;
    logic [KEY_W-1:0]    r_hi_key, r_lo_key;
    logic signed [MARK_W-1:0] r_hi_mark, r_lo_mark;
    logic signed [SUM_W-1:0]  r_sum;
    logic                r_neg;
    logic                r_out_valid;

    logic [CNT_W-1:0]    w_cap;
    logic [KEY_W-1:0]    w_rkey;
    logic signed [MARK_W-1:0] w_rmark;
    logic                w_wr;
    logic [ADDR_W-1:0]   w_waddr;
    logic [WORD_W-1:0]   w_wdata;
    logic [SUM_W-1:0]    w_mag;
    logic                w_div_done;
    logic [DIVD_W-1:0]   w_quot;
    logic [AVG_W-1:0]    w_avg;
    logic                w_ok;

    assign w_cap   = (r_capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : r_capacity;
    assign w_rkey  = r_rdata[WORD_W-1:MARK_W];
    assign w_rmark = r_rdata[MARK_W-1:0];

    assign o_sts.op          = r_op;
    assign o_sts.full        = r_count >= w_cap;
    assign o_sts.badpos      = r_pos > r_count;
    assign o_sts.pos_eq_cnt  = r_pos == r_count;
    assign o_sts.empty       = r_count == '0;
    assign o_sts.idx_at_pos  = r_idx == r_pos;
    assign o_sts.idx_at_last = CNT_W'(r_idx + 1'b1) == r_count;
    assign o_sts.hit         = r_hit;
    assign o_sts.hit_last    = CNT_W'({1'b0, r_hit_idx} + 1'b1) == r_count;
    assign o_sts.div_done    = w_div_done;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CNT_W'(DEPTH);
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_capacity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_pos  <= i_position;
            r_key  <= i_student_key;
            r_mark <= i_mark;
        end
    end

    // scan index: read issue side of the store pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_load) begin
            case (i_cmd.idx_sel)
                IDX_ZERO:   r_idx <= '0;
                IDX_CNT_M1: r_idx <= r_count - 1'b1;
                IDX_HIT_P1: r_idx <= CNT_W'({1'b0, r_hit_idx} + 1'b1);
                default:    r_idx <= '0;
            endcase
        end else if (i_cmd.rd) begin
            r_idx <= i_cmd.dir_dn ? r_idx - 1'b1 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata  <= mem[r_idx[ADDR_W-1:0]];
            r_rd_idx <= r_idx[ADDR_W-1:0];
        end
    end

    always_comb begin
        w_wr    = 1'b0;
        w_waddr = r_pos[ADDR_W-1:0];
        w_wdata = {r_key, r_mark};
        if (i_cmd.wr_new) begin
            w_wr = 1'b1;
        end else if (r_rd_vld && i_cmd.mode == MODE_SHIFT_UP) begin
            w_wr    = 1'b1;
            w_waddr = r_rd_idx + 1'b1;
            w_wdata = r_rdata;
        end else if (r_rd_vld && i_cmd.mode == MODE_SHIFT_DN) begin
            w_wr    = 1'b1;
            w_waddr = r_rd_idx - 1'b1;
            w_wdata = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.hit_clr) begin
            r_hit <= 1'b0;
        end else if (r_rd_vld && i_cmd.mode == MODE_MATCH && !r_hit && w_rkey == r_key) begin
            r_hit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld && i_cmd.mode == MODE_MATCH && !r_hit && w_rkey == r_key) begin
            r_hit_idx <= r_rd_idx;
        end
    end

    // strict compares keep the first extreme
    always_ff @(posedge i_clk) begin
        if (r_rd_vld && i_cmd.mode == MODE_STATS) begin
            if (r_rd_idx == '0) begin
                r_hi_idx  <= r_rd_idx;
                r_hi_key  <= w_rkey;
                r_hi_mark <= w_rmark;
                r_lo_idx  <= r_rd_idx;
                r_lo_key  <= w_rkey;
                r_lo_mark <= w_rmark;
                r_sum     <= SUM_W'(w_rmark);
            end else begin
                if (w_rmark > r_hi_mark) begin
                    r_hi_idx  <= r_rd_idx;
                    r_hi_key  <= w_rkey;
                    r_hi_mark <= w_rmark;
                end
                if (w_rmark < r_lo_mark) begin
                    r_lo_idx  <= r_rd_idx;
                    r_lo_key  <= w_rkey;
                    r_lo_mark <= w_rmark;
                end
                r_sum <= r_sum + SUM_W'(w_rmark);
            end
        end
    end

    assign w_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : r_sum;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg <= r_sum[SUM_W-1];
        end
    end

    olws_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({w_mag[SUM_W-2:0], 8'd0}),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_avg = r_neg ? AVG_W'(-w_quot) : w_quot[AVG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
    end

    assign w_ok = r_status == ST_OK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            o_status      <= r_status;
            o_entry_total <= r_count;
            o_found_index <= (w_ok && (r_op == OP_FIND || r_op == OP_DELETE)) ? r_hit_idx : '0;
            if (w_ok && r_op == OP_STATS) begin
                o_max_index    <= r_hi_idx;
                o_max_key      <= r_hi_key;
                o_max_mark     <= r_hi_mark;
                o_min_index    <= r_lo_idx;
                o_min_key      <= r_lo_key;
                o_min_mark     <= r_lo_mark;
                o_average_mark <= w_avg;
            end else begin
                o_max_index    <= '0;
                o_max_key      <= '0;
                o_max_mark     <= '0;
                o_min_index    <= '0;
                o_min_key      <= '0;
                o_min_mark     <= '0;
                o_average_mark <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

>>> hw/rtl/olws_ctrl.sv
// Controller state machine sequencing each list operation.
`timescale 1ns / 1ps
`default_nettype none
module olws_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  olws_pkg::t_sts  i_sts,
    output olws_pkg::t_cmd  o_cmd
);
    import olws_pkg::*;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DISPATCH   = 4'd1;
    localparam logic [3:0] S_INS_SHIFT  = 4'd2;
    localparam logic [3:0] S_INS_DRAIN  = 4'd3;
    localparam logic [3:0] S_INS_NEW    = 4'd4;
    localparam logic [3:0] S_MATCH      = 4'd5;
    localparam logic [3:0] S_MATCH_DRN  = 4'd6;
    localparam logic [3:0] S_MATCH_END  = 4'd7;
    localparam logic [3:0] S_DEL_SHIFT  = 4'd8;
    localparam logic [3:0] S_DEL_DRAIN  = 4'd9;
    localparam logic [3:0] S_STATS      = 4'd10;
    localparam logic [3:0] S_STATS_DRN  = 4'd11;
    localparam logic [3:0] S_DIV        = 4'd12;
    localparam logic [3:0] S_FINISH     = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_div_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.hit_clr  = 1'b1;
                o_cmd.idx_load = 1'b1;
                o_cmd.idx_sel  = IDX_ZERO;
                case (i_sts.op)
                    OP_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                            n_state          = S_FINISH;
                        end else if (i_sts.badpos) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_BADPOS;
                            n_state          = S_FINISH;
                        end else if (i_sts.pos_eq_cnt) begin
                            n_state = S_INS_NEW;
                        end else begin
                            o_cmd.idx_sel = IDX_CNT_M1;
                            n_state       = S_INS_SHIFT;
                        end
                    end
                    OP_FIND, OP_DELETE: begin
                        if (i_sts.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_NOTFOUND;
                            n_state          = S_FINISH;
                        end else begin
                            n_state = S_MATCH;
                        end
                    end
                    default: begin
                        if (i_sts.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                            n_state          = S_FINISH;
                        end else begin
                            n_state = S_STATS;
                        end
                    end
                endcase
            end
            S_INS_SHIFT: begin
                o_cmd.rd     = 1'b1;
                o_cmd.dir_dn = 1'b1;
                o_cmd.mode   = MODE_SHIFT_UP;
                if (i_sts.idx_at_pos) begin
                    n_state = S_INS_DRAIN;
                end
            end
            S_INS_DRAIN: begin
                o_cmd.mode = MODE_SHIFT_UP;
                n_state    = S_INS_NEW;
            end
            S_INS_NEW: begin
                o_cmd.wr_new     = 1'b1;
                o_cmd.cnt_inc    = 1'b1;
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ST_OK;
                n_state          = S_FINISH;
            end
            S_MATCH: begin
                o_cmd.rd   = 1'b1;
                o_cmd.mode = MODE_MATCH;
                if (i_sts.idx_at_last) begin
                    n_state = S_MATCH_DRN;
                end
            end
            S_MATCH_DRN: begin
                o_cmd.mode = MODE_MATCH;
                n_state    = S_MATCH_END;
            end
            S_MATCH_END: begin
                o_cmd.set_status = 1'b1;
                n_state          = S_FINISH;
                if (!i_sts.hit) begin
                    o_cmd.status = ST_NOTFOUND;
                end else begin
                    o_cmd.status = ST_OK;
                    if (i_sts.op == OP_DELETE) begin
                        if (i_sts.hit_last) begin
                            o_cmd.cnt_dec = 1'b1;
                        end else begin
                            o_cmd.idx_load = 1'b1;
                            o_cmd.idx_sel  = IDX_HIT_P1;
                            n_state        = S_DEL_SHIFT;
                        end
                    end
                end
            end
            S_DEL_SHIFT: begin
                o_cmd.rd   = 1'b1;
                o_cmd.mode = MODE_SHIFT_DN;
                if (i_sts.idx_at_last) begin
                    n_state = S_DEL_DRAIN;
                end
            end
            S_DEL_DRAIN: begin
                o_cmd.mode    = MODE_SHIFT_DN;
                o_cmd.cnt_dec = 1'b1;
                n_state       = S_FINISH;
            end
            S_STATS: begin
                o_cmd.rd   = 1'b1;
                o_cmd.mode = MODE_STATS;
                if (i_sts.idx_at_last) begin
                    n_state = S_STATS_DRN;
                end
            end
            S_STATS_DRN: begin
                o_cmd.mode = MODE_STATS;
                n_state    = S_DIV;
                // divider starts the cycle after the last sum update
            end
            S_DIV: begin
                // done still shows the previous division in the start cycle
                if (i_sts.div_done && !r_div_go) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_OK;
                    n_state          = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.div_start = r_div_go;
    end

    // one-cycle start pulse on entry to the divide wait
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= r_state == S_STATS_DRN;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/ordered_list_with_stats.sv
// Top level of the ordered list with statistics block.
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to 64 (key, mark) entries with insert, find, delete and
// statistics. One operation is in flight at a time; the result sits in an
// output register so a new operation is accepted while it waits. The entry
// store has one read and one write port. Insert shifts the entries from pos
// up (none on append), find scans the whole list, delete scans then shifts
// the entries after the match down (none when the match is last), statistics
// scans and then waits on the bit-serial average divider; a stalled output
// register adds its wait. Capacity is written on the always ready
// configuration channel by the user only while idle; the block does not check.
module ordered_list_with_stats (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire [olws_pkg::CNT_W-1:0]            i_cfg_capacity,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire [1:0]                            i_operation,
    input  wire [olws_pkg::CNT_W-1:0]            i_position,
    input  wire [olws_pkg::KEY_W-1:0]            i_student_key,
    input  wire signed [olws_pkg::MARK_W-1:0]    i_mark,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic [olws_pkg::STATUS_W-1:0]        o_status,
    output logic [olws_pkg::ADDR_W-1:0]          o_found_index,
    output logic [olws_pkg::CNT_W-1:0]           o_entry_total,
    output logic [olws_pkg::ADDR_W-1:0]          o_max_index,
    output logic [olws_pkg::KEY_W-1:0]           o_max_key,
    output logic signed [olws_pkg::MARK_W-1:0]   o_max_mark,
    output logic [olws_pkg::ADDR_W-1:0]          o_min_index,
    output logic [olws_pkg::KEY_W-1:0]           o_min_key,
    output logic signed [olws_pkg::MARK_W-1:0]   o_min_mark,
    output logic signed [olws_pkg::AVG_W-1:0]    o_average_mark
);
    import olws_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    olws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    olws_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_capacity (i_cfg_capacity),
        .i_operation    (i_operation),
        .i_position     (i_position),
        .i_student_key  (i_student_key),
        .i_mark         (i_mark),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_found_index  (o_found_index),
        .o_entry_total  (o_entry_total),
        .o_max_index    (o_max_index),
        .o_max_key      (o_max_key),
        .o_max_mark     (o_max_mark),
        .o_min_index    (o_min_index),
        .o_min_key      (o_min_key),
        .o_min_mark     (o_min_mark),
        .o_average_mark (o_average_mark)
    );

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_total <= 7'd64)
        else $error("entry total above store depth");

    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_entry_total == 7'd0)
        else $error("empty status with entries present");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_min_mark <= o_max_mark)
        else $error("lowest mark above highest mark");

endmodule
`default_nettype wire

>>> test/ordered_list_with_stats_chk.sv
// Checker for the ordered list block: predicts every result and compares it.
`timescale 1ns / 1ps
module ordered_list_with_stats_chk
    import olws_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_valid,
    input  wire                       i_cfg_ready,
    input  wire [CNT_W-1:0]           i_cfg_capacity,
    input  wire                       i_in_valid,
    input  wire                       i_in_ready,
    input  wire [1:0]                 i_operation,
    input  wire [CNT_W-1:0]           i_position,
    input  wire [KEY_W-1:0]           i_student_key,
    input  wire signed [MARK_W-1:0]   i_mark,
    input  wire                       i_out_valid,
    input  wire                       i_out_ready,
    input  wire [STATUS_W-1:0]        i_status,
    input  wire [ADDR_W-1:0]          i_found_index,
    input  wire [CNT_W-1:0]           i_entry_total,
    input  wire [ADDR_W-1:0]          i_max_index,
    input  wire [KEY_W-1:0]           i_max_key,
    input  wire signed [MARK_W-1:0]   i_max_mark,
    input  wire [ADDR_W-1:0]          i_min_index,
    input  wire [KEY_W-1:0]           i_min_key,
    input  wire signed [MARK_W-1:0]   i_min_mark,
    input  wire signed [AVG_W-1:0]    i_average_mark,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_list_count
);

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [ADDR_W-1:0]        found_index;
        logic [CNT_W-1:0]         entry_total;
        logic [ADDR_W-1:0]        max_index;
        logic [KEY_W-1:0]         max_key;
        logic signed [MARK_W-1:0] max_mark;
        logic [ADDR_W-1:0]        min_index;
        logic [KEY_W-1:0]         min_key;
        logic signed [MARK_W-1:0] min_mark;
        logic signed [AVG_W-1:0]  average_mark;
    } t_result;

    logic [KEY_W-1:0]         keys [DEPTH];
    logic signed [MARK_W-1:0] marks [DEPTH];
    int                       count;
    int                       limit;
    t_result                  awaited [$];
    int                       fails;

    assign o_fail_count = fails;
    assign o_pending    = awaited.size();
    assign o_list_count = count;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
        fails++;
    endtask

    function automatic t_result apply_operation(input logic [1:0] op, input int pos,
                                                input logic [KEY_W-1:0] key,
                                                input logic signed [MARK_W-1:0] mark);
        t_result r;
        int at;
        int hi;
        int lo;
        longint sum;
        longint avg;
        r = '0;
        at = -1;
        case (op)
            OP_INSERT: begin
                if (count >= limit) begin
                    r.status = ST_FULL;
                end else if (pos > count) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (int i = count; i > pos; i--) begin
                        keys[i] = keys[i-1];
                        marks[i] = marks[i-1];
                    end
                    keys[pos] = key;
                    marks[pos] = mark;
                    count++;
                    r.status = ST_OK;
                end
            end
            OP_FIND, OP_DELETE: begin
                for (int i = 0; i < count; i++) begin
                    if (at < 0 && keys[i] == key) at = i;
                end
                if (at < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.status = ST_OK;
                    r.found_index = at[ADDR_W-1:0];
                    if (op == OP_DELETE) begin
                        for (int i = at + 1; i < count; i++) begin
                            keys[i-1] = keys[i];
                            marks[i-1] = marks[i];
                        end
                        count--;
                    end
                end
            end
            default: begin
                if (count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    hi = 0;
                    lo = 0;
                    sum = marks[0];
                    for (int i = 1; i < count; i++) begin
                        if (marks[i] > marks[hi]) hi = i;
                        if (marks[i] < marks[lo]) lo = i;
                        sum += marks[i];
                    end
                    avg = (sum * 256) / count;
                    r.status = ST_OK;
                    r.max_index = hi[ADDR_W-1:0];
                    r.max_key = keys[hi];
                    r.max_mark = marks[hi];
                    r.min_index = lo[ADDR_W-1:0];
                    r.min_key = keys[lo];
                    r.min_mark = marks[lo];
                    r.average_mark = avg[AVG_W-1:0];
                end
            end
        endcase
        r.entry_total = count[CNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            count = 0;
            limit = DEPTH;
            fails = 0;
            awaited.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                limit = (i_cfg_capacity > DEPTH) ? DEPTH : int'(i_cfg_capacity);
            end
            if (i_in_valid && i_in_ready) begin
                awaited.push_back(apply_operation(i_operation, int'(i_position),
                                                  i_student_key, i_mark));
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited.size() == 0) begin
                    report("unexpected result", i_status, -1);
                end else begin
                    want = awaited.pop_front();
                    if (i_status != want.status) report("status", i_status, want.status);
                    if (i_found_index != want.found_index)
                        report("found_index", i_found_index, want.found_index);
                    if (i_entry_total != want.entry_total)
                        report("entry_total", i_entry_total, want.entry_total);
                    if (i_max_index != want.max_index)
                        report("max_index", i_max_index, want.max_index);
                    if (i_max_key != want.max_key) report("max_key", i_max_key, want.max_key);
                    if (i_max_mark != want.max_mark)
                        report("max_mark", i_max_mark, want.max_mark);
                    if (i_min_index != want.min_index)
                        report("min_index", i_min_index, want.min_index);
                    if (i_min_key != want.min_key) report("min_key", i_min_key, want.min_key);
                    if (i_min_mark != want.min_mark)
                        report("min_mark", i_min_mark, want.min_mark);
                    if (i_average_mark != want.average_mark)
                        report("average_mark", i_average_mark, want.average_mark);
                end
            end
        end
    end

endmodule

>>> test/ordered_list_with_stats_tb.sv
// Testbench top for the ordered list block: stimulus, idling and verdict.
`timescale 1ns / 1ps
module ordered_list_with_stats_tb;
    import olws_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic [CNT_W-1:0]         i_cfg_capacity = '0;
    logic                     i_in_valid = 1'b0;
    logic [1:0]               i_operation = OP_INSERT;
    logic [CNT_W-1:0]         i_position = '0;
    logic [KEY_W-1:0]         i_student_key = '0;
    logic signed [MARK_W-1:0] i_mark = '0;
    logic                     i_out_ready = 1'b0;
    wire                      o_cfg_ready;
    wire                      o_in_ready;
    wire                      o_out_valid;
    wire [STATUS_W-1:0]       o_status;
    wire [ADDR_W-1:0]         o_found_index;
    wire [CNT_W-1:0]          o_entry_total;
    wire [ADDR_W-1:0]         o_max_index;
    wire [KEY_W-1:0]          o_max_key;
    wire signed [MARK_W-1:0]  o_max_mark;
    wire [ADDR_W-1:0]         o_min_index;
    wire [KEY_W-1:0]          o_min_key;
    wire signed [MARK_W-1:0]  o_min_mark;
    wire signed [AVG_W-1:0]   o_average_mark;
    int                       fail_count;
    int                       pending;
    int                       list_count;
    int                       stall_left;
    logic [KEY_W-1:0]         used_keys [$];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    ordered_list_with_stats dut (.*);

    ordered_list_with_stats_chk u_chk (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_capacity,
        .i_in_valid, .i_in_ready(o_in_ready), .i_operation, .i_position,
        .i_student_key, .i_mark,
        .i_out_valid(o_out_valid), .i_out_ready, .i_status(o_status),
        .i_found_index(o_found_index), .i_entry_total(o_entry_total),
        .i_max_index(o_max_index), .i_max_key(o_max_key), .i_max_mark(o_max_mark),
        .i_min_index(o_min_index), .i_min_key(o_min_key), .i_min_mark(o_min_mark),
        .i_average_mark(o_average_mark),
        .o_fail_count(fail_count), .o_pending(pending), .o_list_count(list_count)
    );

    // receiver drops ready after each result for a random stall, often none
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left <= 0;
        end else if (o_out_valid && i_out_ready) begin
            i_out_ready <= 1'b0;
            stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // valid stays up straight into the next transaction when there is no gap
    task automatic send(input logic [1:0] op, input int pos, input logic [KEY_W-1:0] key,
                        input logic signed [MARK_W-1:0] mark);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_operation <= op;
        i_position <= pos[CNT_W-1:0];
        i_student_key <= key;
        i_mark <= mark;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (op == OP_INSERT) used_keys.push_back(key);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        // margin in case the last accepting edge is not yet counted as pending
        repeat (120) @(posedge i_clk);
    endtask

    task automatic set_capacity(input int cap);
        drain();
        i_cfg_capacity <= cap[CNT_W-1:0];
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if (used_keys.size() != 0 && $urandom_range(0, 3) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        return KEY_W'($urandom);
    endfunction

    task automatic random_phase(input int n, input int insert_weight);
        int r;
        int pos;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < insert_weight) begin
                pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(0, list_count);
                send(OP_INSERT, pos, KEY_W'($urandom_range(0, 7) == 0 ? pick_key()
                                                                     : $urandom),
                     MARK_W'($urandom_range(0, 4) == 0 ?
                         ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000) : $urandom));
            end else if (r < insert_weight + 20) begin
                send(OP_FIND, $urandom_range(0, 127), pick_key(), MARK_W'($urandom));
            end else if (r < insert_weight + 40) begin
                send(OP_DELETE, $urandom_range(0, 127), pick_key(), MARK_W'($urandom));
            end else begin
                send(OP_STATS, $urandom_range(0, 127), KEY_W'($urandom), MARK_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list cases, extremes, bad position, append, full
        send(OP_STATS, 0, 8'h00, 16'sh0000);
        send(OP_FIND, 0, 8'h00, 16'sh0000);
        send(OP_DELETE, 0, 8'hff, 16'sh0000);
        send(OP_INSERT, 1, 8'h11, 16'sh0001);
        send(OP_INSERT, 127, 8'h11, 16'sh0001);
        send(OP_INSERT, 0, 8'hff, 16'sh7fff);
        send(OP_INSERT, 1, 8'h00, -16'sh8000);
        send(OP_INSERT, 0, 8'h5a, 16'sh7fff);
        send(OP_INSERT, 3, 8'h5a, -16'sh8000);
        send(OP_STATS, 0, 8'h00, 16'sh0000);
        send(OP_FIND, 0, 8'h5a, 16'sh0000);
        send(OP_DELETE, 0, 8'h5a, 16'sh0000);
        send(OP_FIND, 0, 8'h5a, 16'sh0000);
        send(OP_STATS, 0, 8'h00, 16'sh0000);
        send(OP_INSERT, 64, 8'haa, -16'sh0001);
        send(OP_STATS, 0, 8'h00, 16'sh0000);
        set_capacity(2);
        send(OP_INSERT, 0, 8'h01, 16'sh0005);
        send(OP_DELETE, 0, 8'hff, 16'sh0000);
        send(OP_DELETE, 0, 8'h00, 16'sh0000);
        send(OP_DELETE, 0, 8'h5a, 16'sh0000);
        send(OP_DELETE, 0, 8'haa, 16'sh0000);
        set_capacity(0);
        send(OP_INSERT, 0, 8'h77, 16'sh1234);
        set_capacity(127);
        send(OP_INSERT, 0, 8'h77, 16'sh1234);

        // random: fill to the store limit, then mixed, at several capacities
        random_phase(250, 70);
        set_capacity(64);
        random_phase(200, 30);
        set_capacity(1);
        random_phase(100, 40);
        set_capacity(17);
        random_phase(200, 45);
        set_capacity(100);
        random_phase(300, 60);

        drain();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
